// ----- sv/tss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the truncated substring search.
// Used by tss_match, tss_track and truncated_substring_search.
package tss_pkg;

  // Default sizing of the needle and the haystack position bound.
  localparam int              NEEDLE_MAX_DEF   = 16;
  localparam longint unsigned HAYSTACK_MAX_DEF = 64'd65536;

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int POS_OUT_W   = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int NEEDLE_W    = 128;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LOW  = 3'd0,
    REG_NEEDLE_HIGH = 3'd1,
    REG_NEEDLE_LEN  = 3'd2,
    REG_MIN_LEN     = 3'd3,
    REG_CASE_SENS   = 3'd4
  } cfg_reg_t;

  // Configuration register contents.
  typedef struct packed {
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    needle_length;
    logic [LEN_W-1:0]    min_length;
    logic                case_sensitive;
  } cfg_t;

  // One search result.
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [POS_OUT_W-1:0] position;
    logic [LEN_W-1:0]     match_length;
    logic                 overflow;
  } res_t;

  // ASCII a-z to A-Z when case folding is on.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic case_sensitive);
    logic [BYTE_W-1:0] r;
    r = b;
    if (!case_sensitive && b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- sv/tss_match.sv -----
`timescale 1ns / 1ps
// Byte compare bank: one compare of the haystack byte against each needle byte.
// Depends on tss_pkg.
module tss_match #(
  parameter int NEEDLE_MAX = tss_pkg::NEEDLE_MAX_DEF
) (
  input  logic [tss_pkg::BYTE_W-1:0]   data_byte,
  input  tss_pkg::cfg_t                cfg,
  output logic [NEEDLE_MAX-1:0]        mask
);

  logic [tss_pkg::BYTE_W-1:0] fb;

  // Fold the haystack byte once, then compare with every folded needle byte.
  assign fb = tss_pkg::fold_byte(data_byte, cfg.case_sensitive);

  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      mask[k] = (tss_pkg::fold_byte(cfg.needle[k*tss_pkg::BYTE_W +: tss_pkg::BYTE_W],
                                    cfg.case_sensitive) == fb);
    end
  end

endmodule

// ----- sv/tss_track.sv -----
`timescale 1ns / 1ps
// Alignment tracker: shift-and live vector, byte counter and result decision.
// Depends on tss_pkg; takes the compare mask from tss_match.
module tss_track #(
  parameter int              NEEDLE_MAX   = tss_pkg::NEEDLE_MAX_DEF,
  parameter longint unsigned HAYSTACK_MAX = tss_pkg::HAYSTACK_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  last,
  input  logic [NEEDLE_MAX-1:0] mask,
  input  tss_pkg::cfg_t         cfg,
  output tss_pkg::res_t         res
);

  localparam int POS_W = $clog2(HAYSTACK_MAX + 1);
  localparam int PW    = (POS_W > tss_pkg::POS_OUT_W) ? POS_W : tss_pkg::POS_OUT_W;
  localparam int LEN_W = tss_pkg::LEN_W;

  logic [NEEDLE_MAX-1:0] live, live_next;
  logic [POS_W-1:0]      pos;
  logic                  given;

  logic [LEN_W-1:0]      len, minl, back;
  logic [NEEDLE_MAX-1:0] len_mask, keep_mask, live_new, live_kept;
  logic                  ovf, full_hit, part_any, hit;
  logic [LEN_W-1:0]      part_h;
  logic [POS_W-1:0]      start;
  logic [PW-1:0]         start_w;

  // Effective needle length and minimum length.
  always_comb begin
    len = cfg.needle_length;
    if (len == '0) len = LEN_W'(1);
    if (len > LEN_W'(NEEDLE_MAX)) len = LEN_W'(NEEDLE_MAX);
    minl = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
  end

  // Shift-and step over all alignments, full-match check and drop of the top bit.
  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      len_mask[k]  = (LEN_W'(k) < len);
      keep_mask[k] = (LEN_W'(k + 1) < len);
    end
    live_new = NEEDLE_MAX'({live, 1'b1}) & mask & len_mask;
    full_hit = 1'b0;
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      if (LEN_W'(k + 1) == len && live_new[k]) full_hit = 1'b1;
    end
    full_hit  = full_hit && (len >= minl);
    live_kept = live_new & keep_mask;
  end

  // Earliest live alignment, which is the highest set bit.
  always_comb begin
    part_any = 1'b0;
    part_h   = '0;
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      if (live_kept[k]) begin
        part_any = 1'b1;
        part_h   = LEN_W'(k);
      end
    end
  end

  // Result decision and start offset.
  always_comb begin
    ovf   = (pos == POS_W'(HAYSTACK_MAX));
    hit   = full_hit || (part_any && (part_h + LEN_W'(1) >= minl));
    back  = full_hit ? (len - LEN_W'(1)) : part_h;
    start = (pos >= POS_W'(back)) ? (pos - POS_W'(back)) : '0;
    start_w = PW'(start);

    res.valid        = !given && (full_hit || last);
    res.found        = hit;
    res.position     = !hit ? '0 :
                       (start_w > PW'(16'hFFFF)) ? 16'hFFFF : start_w[tss_pkg::POS_OUT_W-1:0];
    res.match_length = !hit ? '0 : (full_hit ? len : part_h + LEN_W'(1));
    res.overflow     = ovf;
  end

  assign live_next = given ? live : live_kept;

  // Per-haystack state; the last byte clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= '0;
      pos   <= '0;
      given <= 1'b0;
    end else if (adv) begin
      if (last) begin
        live  <= '0;
        pos   <= '0;
        given <= 1'b0;
      end else begin
        live <= live_next;
        if (!ovf) pos <= pos + POS_W'(1);
        if (res.valid) given <= 1'b1;
      end
    end
  end

  // The byte counter saturates at the bound.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(HAYSTACK_MAX))
    else $error("byte counter passed the haystack bound");

  // An accepted match never falls short of the minimum length.
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    (adv && res.valid && res.found) |-> (res.match_length >= minl))
    else $error("match shorter than minimum length reported");

  // A not-found result carries zero position and length.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (adv && res.valid && !res.found) |-> (res.position == '0 && res.match_length == '0))
    else $error("not-found result with nonzero fields");

  // The last byte always leaves a clean state behind.
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && last) |=> (pos == '0 && live == '0 && !given))
    else $error("state not cleared after last byte");

  // Once a result is out, no second result for the same haystack.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (adv && res.valid && !last) |=> !res.valid)
    else $error("second result in one haystack");

endmodule

// ----- sv/truncated_substring_search.sv -----
`timescale 1ns / 1ps
// Truncated substring search over a byte stream, one haystack byte per word.
// Each result word passes from the input register through the tracker into the result register.
// Throughput: one byte per cycle; the input register, compare bank and result register
// form a two-stage path, stalled only while the result register holds an untaken word.
// Reset (synchronous, rst high) clears the tracker, both stages and the configuration
// registers to needle 0, needle length 1, minimum length 1, case-sensitive.
module truncated_substring_search #(
  parameter int              NEEDLE_MAX   = tss_pkg::NEEDLE_MAX_DEF,
  parameter longint unsigned HAYSTACK_MAX = tss_pkg::HAYSTACK_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]         cfg_data,
  // Haystack stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tss_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // last
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tss_pkg::OUT_TDATA_W-1:0]   m_tdata    // [0] found, [16:1] position,
                                                       // [21:17] match_length, [22] overflow
);

  tss_pkg::cfg_t              cfg;
  logic                       in_valid;
  logic [tss_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;
  logic                       adv;
  logic [NEEDLE_MAX-1:0]      mask;
  tss_pkg::res_t              res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.needle         <= '0;
      cfg.needle_length  <= tss_pkg::LEN_W'(1);
      cfg.min_length     <= tss_pkg::LEN_W'(1);
      cfg.case_sensitive <= 1'b1;
    end else if (cfg_we) begin
      case (tss_pkg::cfg_reg_t'(cfg_index))
        tss_pkg::REG_NEEDLE_LOW:  cfg.needle[63:0]      <= cfg_data;
        tss_pkg::REG_NEEDLE_HIGH: cfg.needle[127:64]    <= cfg_data;
        tss_pkg::REG_NEEDLE_LEN:  cfg.needle_length     <= cfg_data[tss_pkg::LEN_W-1:0];
        tss_pkg::REG_MIN_LEN:     cfg.min_length        <= cfg_data[tss_pkg::LEN_W-1:0];
        tss_pkg::REG_CASE_SENS:   cfg.case_sensitive    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage handshake: the tracker steps when the result register can take a word.
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[tss_pkg::BYTE_W-1:0];
      in_last <= s_tlast;
    end
  end

  tss_match #(.NEEDLE_MAX(NEEDLE_MAX)) u_match (
    .data_byte (in_byte),
    .cfg       (cfg),
    .mask      (mask)
  );

  tss_track #(.NEEDLE_MAX(NEEDLE_MAX), .HAYSTACK_MAX(HAYSTACK_MAX)) u_track (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .last (in_last),
    .mask (mask),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      m_tdata <= {1'b0, res.overflow, res.match_length, res.position, res.found};
    end
  end

endmodule
